// ===== hw/rtl/timed_wait_queue_assert.svh =====
// Assertion macros for the timed wait queue
`ifndef TIMED_WAIT_QUEUE_ASSERT_SVH
`define TIMED_WAIT_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define TWQ_ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define TWQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define TWQ_ASSERT_IMPLIES(lbl, pre, post, msg)
`define TWQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hw/rtl/twq_pkg.sv =====
// Types and codes shared by the timed wait queue modules
package twq_pkg;

    localparam logic [1:0] KIND_WAIT   = 2'd0;
    localparam logic [1:0] KIND_SIGNAL = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic [2:0] EV_ENQUEUED  = 3'd0;
    localparam logic [2:0] EV_FULL      = 3'd1;
    localparam logic [2:0] EV_SIGNALLED = 3'd2;
    localparam logic [2:0] EV_TIMED_OUT = 3'd3;
    localparam logic [2:0] EV_NO_WAITER = 3'd4;

    // most timeouts released by one tick
    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] ticks;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/twq_cell.sv =====
// One queue slot: loads a broadcast entry or takes its upper neighbor on a shift
module twq_cell
(
    input  logic               clk,
    input  twq_pkg::cell_ctl_t ctl,
    input  twq_pkg::entry_t    load_data,
    input  twq_pkg::entry_t    nb,
    output twq_pkg::entry_t    ent
);

    twq_pkg::entry_t ent_reg;
    twq_pkg::entry_t ent_next;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.load)
        begin
            ent_next = load_data;
        end
        else if (ctl.shift)
        begin
            ent_next = nb;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

// ===== hw/rtl/timed_wait_queue.sv =====
// Timed wait queue: top level with sequencer and chain of queue cells
// Wait and signal requests: accepted in IDLE, result registered from the WAIT or SIG state.
// Tick requests: TICK walks each queued waiter past the chain head in turn, then FLUSH
//   emits the last pending timeout, if any; emitting steps wait while the result port stalls.
// One request at a time; a result waiting at the output stalls only the step that emits.
// Reset (rst_n low, async): queue empty, no result pending; slot contents are not cleared.
module timed_wait_queue
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] kind,
    input  logic [7:0] process_id,
    input  logic [15:0] timeout,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [2:0] event_res,
    output logic [7:0] released_id,
    output logic [4:0] waiting_count,
    output logic       last
);

    `include "timed_wait_queue_assert.svh"

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WAIT  = 5'b00010,
        ST_SIG   = 5'b00100,
        ST_TICK  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [7:0]  pid_reg, pid_next;
    logic [15:0] tmo_reg, tmo_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] step_reg, step_next;
    logic [CW-1:0] rm_reg, rm_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_id_reg, pend_id_next;
    logic [CW-1:0] pend_cnt_reg, pend_cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_ev_reg, out_ev_next;
    logic [7:0]    out_id_reg, out_id_next;
    logic [4:0]    out_cnt_reg, out_cnt_next;
    logic          out_last_reg, out_last_next;

    twq_pkg::entry_t    ent [QUEUE_DEPTH];
    twq_pkg::cell_ctl_t ctl [QUEUE_DEPTH];
    twq_pkg::entry_t    load_data;
    twq_pkg::entry_t    head;
    twq_pkg::entry_t    kept;

    logic          out_busy;
    logic          in_accept;
    logic          pass_active;
    logic          release_now;
    logic          step_go;
    logic          wait_go;
    logic          sig_go;
    logic          full;
    logic [CW-1:0] wp;

    assign head        = ent[0];
    assign out_busy    = out_valid_reg & res_stall;
    assign req_stall   = (state_reg != ST_IDLE);
    assign in_accept   = req_valid & ~req_stall;
    assign full        = (count_reg >= CW'(QUEUE_DEPTH));
    assign wait_go     = (state_reg == ST_WAIT) & ~out_busy;
    assign sig_go      = (state_reg == ST_SIG) & ~out_busy;
    assign pass_active = (state_reg == ST_TICK) & (step_reg != count_reg);
    assign release_now = pass_active & (head.ticks == 16'd1)
                       & (32'(rm_reg) < twq_pkg::MAX_RESULTS);
    assign step_go     = pass_active & ~(release_now & pend_valid_reg & out_busy);
    assign wp          = count_reg - CW'(1) - rm_reg;

    always_comb
    begin
        kept       = head;
        kept.ticks = (head.ticks > 16'd1) ? head.ticks - 16'd1 : head.ticks;
        if (state_reg == ST_WAIT)
        begin
            load_data.id    = pid_reg;
            load_data.ticks = tmo_reg;
        end
        else
        begin
            load_data = kept;
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            ctl[i].shift = (sig_go & (count_reg != '0)) | step_go;
            ctl[i].load  = (wait_go & ~full & (count_reg == CW'(i)))
                         | (step_go & ~release_now & (wp == CW'(i)));
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            twq_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl[i]),
                .load_data (load_data),
                .nb        (ent[i]),
                .ent       (ent[i])
            );
        end
        else
        begin : g_body
            twq_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl[i]),
                .load_data (load_data),
                .nb        (ent[i+1]),
                .ent       (ent[i])
            );
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pid_next        = pid_reg;
        tmo_next        = tmo_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        rm_next         = rm_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_cnt_next   = pend_cnt_reg;
        out_valid_next  = out_valid_reg & res_stall;
        out_ev_next     = out_ev_reg;
        out_id_next     = out_id_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    pid_next  = process_id;
                    tmo_next  = timeout;
                    step_next = '0;
                    rm_next   = '0;
                    case (kind)
                        twq_pkg::KIND_WAIT:   state_next = ST_WAIT;
                        twq_pkg::KIND_SIGNAL: state_next = ST_SIG;
                        twq_pkg::KIND_TICK:   state_next = ST_TICK;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WAIT:
            begin
                if (wait_go)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (full)
                    begin
                        out_ev_next  = twq_pkg::EV_FULL;
                        out_id_next  = 8'd0;
                        out_cnt_next = 5'(count_reg);
                    end
                    else
                    begin
                        count_next   = count_reg + CW'(1);
                        out_ev_next  = twq_pkg::EV_ENQUEUED;
                        out_id_next  = pid_reg;
                        out_cnt_next = 5'(count_reg + CW'(1));
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SIG:
            begin
                if (sig_go)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (count_reg == '0)
                    begin
                        out_ev_next  = twq_pkg::EV_NO_WAITER;
                        out_id_next  = 8'd0;
                        out_cnt_next = 5'(count_reg);
                    end
                    else
                    begin
                        count_next   = count_reg - CW'(1);
                        out_ev_next  = twq_pkg::EV_SIGNALLED;
                        out_id_next  = head.id;
                        out_cnt_next = 5'(count_reg - CW'(1));
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (!pass_active)
                begin
                    count_next = count_reg - rm_reg;
                    state_next = ST_FLUSH;
                end
                else if (step_go)
                begin
                    step_next = step_reg + CW'(1);
                    if (release_now)
                    begin
                        rm_next = rm_reg + CW'(1);
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_ev_next    = twq_pkg::EV_TIMED_OUT;
                            out_id_next    = pend_id_reg;
                            out_cnt_next   = 5'(pend_cnt_reg);
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = head.id;
                        pend_cnt_next   = wp;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_ev_next     = twq_pkg::EV_TIMED_OUT;
                    out_id_next     = pend_id_reg;
                    out_cnt_next    = 5'(pend_cnt_reg);
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            rm_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            rm_reg         <= rm_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg      <= pid_next;
        tmo_reg      <= tmo_next;
        pend_id_reg  <= pend_id_next;
        pend_cnt_reg <= pend_cnt_next;
        out_ev_reg   <= out_ev_next;
        out_id_reg   <= out_id_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    assign res_valid     = out_valid_reg;
    assign event_res     = out_ev_reg;
    assign released_id   = out_id_reg;
    assign waiting_count = out_cnt_reg;
    assign last          = out_last_reg;

    `TWQ_ASSERT_IMPLIES(a_count_bound, 1'b1, count_reg <= CW'(QUEUE_DEPTH),
        "waiter count exceeds queue depth")
    `TWQ_ASSERT_IMPLIES(a_step_bound, state_reg == ST_TICK, step_reg <= count_reg,
        "tick pass ran past the queue tail")
    `TWQ_ASSERT_IMPLIES(a_rm_bound, state_reg == ST_TICK, rm_reg <= step_reg,
        "more releases than visited waiters")
    `TWQ_ASSERT_IMPLIES(a_pend_scope, pend_valid_reg,
        state_reg == ST_TICK || state_reg == ST_FLUSH,
        "pending timeout result outside a tick pass")
    `TWQ_ASSERT_NEXT(a_flush_done, state_reg == ST_FLUSH && !out_busy,
        state_reg == ST_IDLE && !pend_valid_reg,
        "tick pass did not finish after flush")

endmodule

// ===== verif/tb.sv =====
// Testbench for timed_wait_queue: directed table plus random requests, self-checked.
module tb;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQUESTS = 140;
    localparam int HOLD_CYCLES = 300;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] rid;
        logic [4:0] cnt;
        logic       fin;
    } wake_t;

    typedef struct packed {
        logic [7:0]  pid;
        logic [15:0] ticks;
    } waiter_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pid;
        logic [15:0] tmo;
        int          reps;
        int          nexp;
        wake_t       want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  kind;
    logic [7:0]  process_id;
    logic [15:0] timeout;
    logic        res_valid;
    logic        res_stall;
    logic [2:0]  event_res;
    logic [7:0]  released_id;
    logic [4:0]  waiting_count;
    logic        last;

    waiter_t waiters[$];
    wake_t   step_out[$];
    wake_t   pending[$];
    int      errors = 0;
    int      accepted = 0;
    int      cycles = 0;

    // nexp: -1 check against the predictor, 0 no result, 1 the typed result
    stim_row_t dir_rows [0:12] = '{
        '{twq_pkg::KIND_SIGNAL, 8'h00, 16'h0000, 1, 1,
          '{twq_pkg::EV_NO_WAITER, 8'h00, 5'd0, 1'b1}},
        '{twq_pkg::KIND_TICK, 8'h00, 16'h0000, 1, 0, '0},
        '{KIND_UNUSED, 8'hFF, 16'hFFFF, 1, 0, '0},
        '{twq_pkg::KIND_WAIT, 8'hFF, 16'hFFFF, 1, 1,
          '{twq_pkg::EV_ENQUEUED, 8'hFF, 5'd1, 1'b1}},
        '{twq_pkg::KIND_WAIT, 8'h00, 16'h0000, 1, 1,
          '{twq_pkg::EV_ENQUEUED, 8'h00, 5'd2, 1'b1}},
        '{twq_pkg::KIND_WAIT, 8'hA5, 16'h0001, 1, 1,
          '{twq_pkg::EV_ENQUEUED, 8'hA5, 5'd3, 1'b1}},
        '{twq_pkg::KIND_WAIT, 8'h5A, 16'h0002, 1, 1,
          '{twq_pkg::EV_ENQUEUED, 8'h5A, 5'd4, 1'b1}},
        '{twq_pkg::KIND_TICK, 8'h00, 16'h0000, 2, -1, '0},
        '{twq_pkg::KIND_SIGNAL, 8'h00, 16'h0000, 1, 1,
          '{twq_pkg::EV_SIGNALLED, 8'hFF, 5'd1, 1'b1}},
        '{twq_pkg::KIND_SIGNAL, 8'h00, 16'h0000, 1, 1,
          '{twq_pkg::EV_SIGNALLED, 8'h00, 5'd0, 1'b1}},
        '{twq_pkg::KIND_WAIT, 8'h10, 16'h0001, 16, -1, '0},
        '{twq_pkg::KIND_WAIT, 8'h77, 16'h0009, 1, 1,
          '{twq_pkg::EV_FULL, 8'h00, 5'd16, 1'b1}},
        '{twq_pkg::KIND_TICK, 8'h00, 16'h0000, 1, -1, '0}
    };

    timed_wait_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) i_dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void predict_step(input logic [1:0] k, input logic [7:0] p,
                                         input logic [15:0] t);
        waiter_t     kept[$];
        logic [7:0]  gone[$];
        waiter_t     w;
        int          cnt;
        step_out.delete();
        case (k)
            twq_pkg::KIND_WAIT:
            begin
                if (waiters.size() >= QUEUE_DEPTH)
                    step_out.push_back('{twq_pkg::EV_FULL, 8'h00, 5'(waiters.size()), 1'b0});
                else
                begin
                    waiters.push_back('{p, t});
                    step_out.push_back('{twq_pkg::EV_ENQUEUED, p, 5'(waiters.size()), 1'b0});
                end
            end
            twq_pkg::KIND_SIGNAL:
            begin
                if (waiters.size() == 0)
                    step_out.push_back('{twq_pkg::EV_NO_WAITER, 8'h00, 5'd0, 1'b0});
                else
                begin
                    w = waiters.pop_front();
                    step_out.push_back('{twq_pkg::EV_SIGNALLED, w.pid, 5'(waiters.size()),
                                         1'b0});
                end
            end
            twq_pkg::KIND_TICK:
            begin
                foreach (waiters[i])
                begin
                    w = waiters[i];
                    if (w.ticks == 16'd1 && gone.size() < twq_pkg::MAX_RESULTS)
                        gone.push_back(w.pid);
                    else
                    begin
                        if (w.ticks > 16'd1)
                            w.ticks = w.ticks - 16'd1;
                        kept.push_back(w);
                    end
                end
                waiters = kept;
                cnt = kept.size() + gone.size();
                foreach (gone[i])
                begin
                    cnt--;
                    step_out.push_back('{twq_pkg::EV_TIMED_OUT, gone[i], 5'(cnt), 1'b0});
                end
            end
            default:
            begin
            end
        endcase
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].fin = 1'b1;
    endfunction

    task automatic send_request(input logic [1:0] k, input logic [7:0] p,
                                input logic [15:0] t, input int nexp, input wake_t want);
        @(negedge clk);
        req_valid <= 1'b1;
        kind <= k;
        process_id <= p;
        timeout <= t;
        do
            @(posedge clk);
        while (req_stall);
        predict_step(k, p, t);
        if (nexp < 0)
            foreach (step_out[j])
                pending.push_back(step_out[j]);
        else if (nexp == 1)
            pending.push_back(want);
        accepted++;
    endtask

    task automatic pause_sender(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        pause_sender(1);
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        wake_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending.size() == 0)
            begin
                $error("unexpected result: event_res %0d released_id %0d", event_res,
                       released_id);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (event_res !== want.ev)
                begin
                    $error("event_res expected %0d got %0d", want.ev, event_res);
                    errors++;
                end
                if (released_id !== want.rid)
                begin
                    $error("released_id expected %0d got %0d", want.rid, released_id);
                    errors++;
                end
                if (waiting_count !== want.cnt)
                begin
                    $error("waiting_count expected %0d got %0d", want.cnt, waiting_count);
                    errors++;
                end
                if (last !== want.fin)
                begin
                    $error("last expected %0d got %0d", want.fin, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall stretches, one long hold-off mid run
    initial
    begin
        int run;
        int pct;
        bit hold_done;
        hold_done = 1'b0;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && accepted >= 80)
            begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    res_stall <= 1'b1;
                end
            end
            else
            begin
                run = $urandom_range(8, 40);
                pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(20, 70);
                repeat (run)
                begin
                    @(negedge clk);
                    res_stall <= ($urandom_range(0, 99) < pct);
                end
            end
        end
    end

    initial
    begin
        stim_row_t   row;
        logic [1:0]  k;
        logic [7:0]  p;
        logic [15:0] t;
        int          sent;
        int          burst;
        int          roll;
        int          wait_pct;
        rst_n = 1'b0;
        req_valid = 1'b0;
        kind = twq_pkg::KIND_WAIT;
        process_id = 8'h00;
        timeout = 16'h0000;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            for (int q = 0; q < row.reps; q++)
                send_request(row.kind, row.pid + 8'(q), row.tmo, row.nexp, row.want);
        end
        drain_results();

        sent = 0;
        burst = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            if (sent == 120)
                drain_results();
            if (burst == 0)
            begin
                pause_sender($urandom_range(0, 6));
                burst = $urandom_range(1, 10);
            end
            wait_pct = ((sent / 40) % 2 == 0) ? 60 : 30;
            roll = $urandom_range(0, 99);
            if (roll < wait_pct)
                k = twq_pkg::KIND_WAIT;
            else if (roll < wait_pct + 20)
                k = twq_pkg::KIND_SIGNAL;
            else if (roll < 96)
                k = twq_pkg::KIND_TICK;
            else
                k = KIND_UNUSED;
            p = 8'($urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            if (roll < 50)
                t = 16'($urandom_range(1, 4));
            else if (roll < 65)
                t = 16'd0;
            else if (roll < 80)
                t = 16'($urandom_range(5, 20));
            else
                t = 16'($urandom_range(0, 65535));
            send_request(k, p, t, -1, '0);
            burst--;
            if (k != KIND_UNUSED)
                sent++;
        end

        drain_results();
        repeat (QUEUE_DEPTH + 4) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
